### src/lgse_pkg.sv
// Package: shared types and constants for the toroidal life grid engine.
`default_nettype none

package lgse_pkg;

  localparam int DEF_ROWS    = 64;
  localparam int DEF_COLS    = 64;

  localparam int OP_W        = 2;
  localparam int ROW_FIELD_W = 6;
  localparam int COL_FIELD_W = 6;

  // neighbour count and the rule thresholds
  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT = NBR_W'(3);
  localparam logic [NBR_W-1:0] KEEP_COUNT  = NBR_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ADV,
    ST_DELIVER
  } state_t;

endpackage

`default_nettype wire

### src/lgse_cmd_if.sv
// Interface: command channel (operation, cell address, write value).
`default_nettype none

interface lgse_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [lgse_pkg::OP_W-1:0]         operation;
  logic [lgse_pkg::ROW_FIELD_W-1:0]  row;
  logic [lgse_pkg::COL_FIELD_W-1:0]  col;
  logic                              cell_in;

  modport source (output valid, output operation, output row, output col, output cell_in,
                  input ready);
  modport sink   (input valid, input operation, input row, input col, input cell_in,
                  output ready);
endinterface

`default_nettype wire

### src/lgse_res_if.sv
// Interface: result channel (read value and completed operation code).
`default_nettype none

interface lgse_res_if;
  logic                      valid;
  logic                      ready;
  logic                      read_value;
  logic [lgse_pkg::OP_W-1:0] done_operation;

  modport source (output valid, output read_value, output done_operation, input ready);
  modport sink   (input valid, input read_value, input done_operation, output ready);
endinterface

`default_nettype wire

### src/lgse_row_rule.sv
// Next-generation rule for one grid row, given the rows above and below (columns wrap).
`default_nettype none

module lgse_row_rule #(
  parameter int COLS = lgse_pkg::DEF_COLS
) (
  input  wire logic [COLS-1:0] above,
  input  wire logic [COLS-1:0] middle,
  input  wire logic [COLS-1:0] below,
  output logic      [COLS-1:0] next_row
);

  for (genvar c = 0; c < COLS; c++) begin : g_col
    localparam int L = (c == 0) ? COLS - 1 : c - 1;
    localparam int R = (c == COLS - 1) ? 0 : c + 1;

    logic [lgse_pkg::NBR_W-1:0] nbr;

    assign nbr = lgse_pkg::NBR_W'(above[L]) + lgse_pkg::NBR_W'(above[c])
               + lgse_pkg::NBR_W'(above[R]) + lgse_pkg::NBR_W'(middle[L])
               + lgse_pkg::NBR_W'(middle[R]) + lgse_pkg::NBR_W'(below[L])
               + lgse_pkg::NBR_W'(below[c]) + lgse_pkg::NBR_W'(below[R]);

    assign next_row[c] = (nbr == lgse_pkg::BIRTH_COUNT) ||
                         ((nbr == lgse_pkg::KEEP_COUNT) && middle[c]);
  end

endmodule

`default_nettype wire

### src/life_grid_step_engine_unit.sv
// Top level: toroidal life grid engine with two row-wide grid memories.
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------
//  cmd     | in  | operation, row, col, cell_in     | valid/ready
//  res     | out | read_value, done_operation       | valid/ready
//
// Each grid memory holds one row of COLS cells per entry; one read and one write a cycle.
// An advance reads one source row a cycle and writes one new row a cycle, with the rule
// evaluated over a whole row at once.
// After reset both grids are cleared one row a cycle, with cmd.ready low.
// A finished result sits in an internal register while res is stalled; the next item is
// still taken and executed, and its result waits for the output register to free up.
// Operation code 3 is taken and gives no result.
`default_nettype none

module life_grid_step_engine_unit #(
  parameter int ROWS = lgse_pkg::DEF_ROWS,
  parameter int COLS = lgse_pkg::DEF_COLS
) (
  input wire logic clk,
  input wire logic rst,
  lgse_cmd_if.sink   cmd,
  lgse_res_if.source res
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int CNT_W = $clog2(ROWS + 3);

  lgse_pkg::state_t state, state_next;

  logic                  current_is_b;
  logic [ROW_W-1:0]      clr_addr;
  logic [CNT_W-1:0]      step;

  logic [COLS-1:0]       grid_a [ROWS];
  logic [COLS-1:0]       grid_b [ROWS];
  logic [COLS-1:0]       rd_a, rd_b, cur_rd;

  logic [COLS-1:0]       prev_row, this_row, first_row;
  logic [COLS-1:0]       new_in, gen_row;

  logic [ROW_W-1:0]      rd_addr;
  logic [ROW_W-1:0]      wr_row_addr;
  logic [COLS-1:0]       wr_row_data;
  logic                  wr_row_a, wr_row_b, wr_bit_a, wr_bit_b;

  logic                  accept, cmd_inside;
  logic [ROW_W-1:0]      cmd_row_idx;
  logic [COL_W-1:0]      cmd_col_idx;
  logic [COL_W-1:0]      col_q;
  logic                  inside_q;

  logic                  res_value;
  logic [lgse_pkg::OP_W-1:0] res_op;
  logic                  out_valid, out_value, load_out;
  logic [lgse_pkg::OP_W-1:0] out_op;

  logic                  adv_last, adv_arrive;

  assign accept      = cmd.valid && cmd.ready;
  assign cmd_inside  = (int'(cmd.row) < ROWS) && (int'(cmd.col) < COLS);
  assign cmd_row_idx = ROW_W'(cmd.row);
  assign cmd_col_idx = COL_W'(cmd.col);

  assign cur_rd     = current_is_b ? rd_b : rd_a;
  assign adv_last   = (step == CNT_W'(ROWS + 2));
  assign adv_arrive = (step != '0) && (step <= CNT_W'(ROWS + 1));
  // last row wraps onto row 0, kept aside at the start of the pass
  assign new_in     = adv_last ? first_row : cur_rd;
  assign load_out   = (state == lgse_pkg::ST_DELIVER) && (!out_valid || res.ready);

  lgse_row_rule #(
    .COLS (COLS)
  ) u_rule (
    .above    (prev_row),
    .middle   (this_row),
    .below    (new_in),
    .next_row (gen_row)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lgse_pkg::ST_CLEAR: begin
        if (clr_addr == ROW_W'(ROWS - 1)) state_next = lgse_pkg::ST_IDLE;
      end
      lgse_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.operation)
            lgse_pkg::OP_WRITE:   state_next = lgse_pkg::ST_DELIVER;
            lgse_pkg::OP_READ:    state_next = lgse_pkg::ST_READ;
            lgse_pkg::OP_ADVANCE: state_next = lgse_pkg::ST_ADV;
            default:              state_next = lgse_pkg::ST_IDLE;
          endcase
        end
      end
      lgse_pkg::ST_READ:    state_next = lgse_pkg::ST_DELIVER;
      lgse_pkg::ST_ADV: begin
        if (adv_last) state_next = lgse_pkg::ST_DELIVER;
      end
      lgse_pkg::ST_DELIVER: begin
        if (!out_valid || res.ready) state_next = lgse_pkg::ST_IDLE;
      end
      default:              state_next = lgse_pkg::ST_CLEAR;
    endcase
  end

  // outputs: handshake, memory addresses and write strobes
  always_comb begin
    cmd.ready   = 1'b0;
    rd_addr     = cmd_row_idx;
    wr_row_a    = 1'b0;
    wr_row_b    = 1'b0;
    wr_row_addr = '0;
    wr_row_data = gen_row;
    wr_bit_a    = 1'b0;
    wr_bit_b    = 1'b0;
    case (state)
      lgse_pkg::ST_CLEAR: begin
        wr_row_a    = 1'b1;
        wr_row_b    = 1'b1;
        wr_row_addr = clr_addr;
        wr_row_data = '0;
      end
      lgse_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid && (cmd.operation == lgse_pkg::OP_WRITE) && cmd_inside) begin
          wr_bit_a = !current_is_b;
          wr_bit_b = current_is_b;
        end
      end
      lgse_pkg::ST_ADV: begin
        // rows fetched in the order last, 0, 1, ..., last
        if (step == '0) begin
          rd_addr = ROW_W'(ROWS - 1);
        end else if (step <= CNT_W'(ROWS)) begin
          rd_addr = ROW_W'(step - CNT_W'(1));
        end else begin
          rd_addr = '0;
        end
        if (step >= CNT_W'(3)) begin
          wr_row_a    = current_is_b;
          wr_row_b    = !current_is_b;
          wr_row_addr = ROW_W'(step - CNT_W'(3));
        end
      end
      default: begin
        rd_addr = cmd_row_idx;
      end
    endcase
  end

  // grid memories
  always_ff @(posedge clk) begin
    if (wr_row_a) begin
      grid_a[wr_row_addr] <= wr_row_data;
    end else if (wr_bit_a) begin
      grid_a[cmd_row_idx][cmd_col_idx] <= cmd.cell_in;
    end
    rd_a <= grid_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_row_b) begin
      grid_b[wr_row_addr] <= wr_row_data;
    end else if (wr_bit_b) begin
      grid_b[cmd_row_idx][cmd_col_idx] <= cmd.cell_in;
    end
    rd_b <= grid_b[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lgse_pkg::ST_CLEAR;
      current_is_b <= 1'b0;
      clr_addr     <= '0;
      step         <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lgse_pkg::ST_CLEAR) clr_addr <= clr_addr + ROW_W'(1);
      if (state == lgse_pkg::ST_ADV) begin
        step <= step + CNT_W'(1);
      end else begin
        step <= '0;
      end
      if ((state == lgse_pkg::ST_ADV) && adv_last) current_is_b <= !current_is_b;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      col_q     <= cmd_col_idx;
      inside_q  <= cmd_inside;
      res_op    <= cmd.operation;
      res_value <= 1'b0;
    end
    if (state == lgse_pkg::ST_READ) begin
      res_value <= inside_q ? cur_rd[col_q] : 1'b0;
    end
    if ((state == lgse_pkg::ST_ADV) && adv_arrive) begin
      prev_row <= this_row;
      this_row <= cur_rd;
      if (step == CNT_W'(2)) first_row <= cur_rd;
    end
    if (load_out) begin
      out_value <= res_value;
      out_op    <= res_op;
    end
  end

  assign res.valid          = out_valid;
  assign res.read_value     = out_value;
  assign res.done_operation = out_op;

endmodule

`default_nettype wire
